### design/beg_pkg.sv
// Shared types, constants and helpers for the brightness envelope generator.
package beg_pkg;

  localparam int unsigned LevelW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned NumW   = 34;

  localparam logic signed [LevelW-1:0] LevelOne   = 32'sd65536;
  localparam logic signed [LevelW-1:0] LevelTenth = 32'sd6554;
  localparam logic signed [LevelW-1:0] TopReset   = 32'sd65536000;
  localparam logic signed [LevelW-1:0] BotReset   = 32'sd0;
  localparam logic signed [LevelW-1:0] SatMax     = 32'sh7fffffff;
  localparam logic signed [LevelW-1:0] SatMin     = 32'sh80000000;

  localparam logic [2:0] FuncTick  = 3'd0;
  localparam logic [2:0] FuncGlide = 3'd1;
  localparam logic [2:0] FuncStep  = 3'd2;
  localparam logic [2:0] FuncAccel = 3'd3;
  localparam logic [2:0] FuncLoop  = 3'd4;
  localparam logic [2:0] FuncBeat  = 3'd5;
  localparam logic [2:0] FuncStop  = 3'd6;

  localparam logic [2:0] ModeIdle = 3'd0;
  localparam logic [2:0] ModeLin  = 3'd1;
  localparam logic [2:0] ModeAcc  = 3'd2;
  localparam logic [2:0] ModeLoop = 3'd3;
  localparam logic [2:0] ModeBeat = 3'd4;

  localparam logic CfgTop = 1'b0;
  localparam logic CfgBot = 1'b1;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [LevelW-1:0] target;
    logic signed [LevelW-1:0] velocity;
    logic signed [LevelW-1:0] accel;
    logic [CountW-1:0]        spend_frames;
    logic [CountW-1:0]        attack_frames;
    logic [CountW-1:0]        rest_frames;
    logic [CountW-1:0]        half_beats;
  } in_item_t;

  typedef struct packed {
    logic signed [LevelW-1:0] level;
    logic [2:0]               mode;
    logic [LevelW-1:0]        frame_number;
  } out_item_t;

  typedef struct packed {
    logic                   start;
    logic signed [NumW-1:0] num;
    logic signed [17:0]     den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [LevelW-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [LevelW-1:0] sat_add(
    input logic signed [LevelW-1:0] a,
    input logic signed [LevelW-1:0] b
  );
    logic signed [LevelW:0] s;
    s = {a[LevelW-1], a} + {b[LevelW-1], b};
    if (s[LevelW] != s[LevelW-1]) begin
      return s[LevelW] ? SatMin : SatMax;
    end
    return s[LevelW-1:0];
  endfunction

endpackage

### design/beg_div.sv
// Sequential signed divider, truncating toward zero, saturated to 32 bits.
module beg_div (
  input  logic             clk,
  input  logic             rst_n,
  input  beg_pkg::div_req_t req,
  output beg_pkg::div_rsp_t rsp
);

  localparam int unsigned NW = beg_pkg::NumW;
  localparam int unsigned DW = 17;

  logic          busy_r, busy_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic          zero_r, zero_nxt;
  logic          done_r, done_nxt;
  logic signed [beg_pkg::LevelW-1:0] q_r, q_nxt;

  logic [NW-1:0]  mag_n;
  logic [17:0]    mag_d;
  logic [DW:0]    shifted;
  logic [DW:0]    trial;
  logic [NW:0]    sq;

  always_comb begin
    mag_n = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    mag_d = req.den[17] ? 18'(-req.den) : 18'(req.den);
    shifted = {rem_r[DW-1:0], quo_r[NW-1]};
    trial = shifted - {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    sq       = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'(NW);
      quo_nxt  = mag_n;
      rem_nxt  = '0;
      dvs_nxt  = mag_d[DW-1:0];
      neg_nxt  = req.num[NW-1] ^ req.den[17];
      zero_nxt = (req.den == '0);
    end else if (busy_r) begin
      if (!trial[DW]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        sq = neg_r ? -{1'b0, quo_nxt} : {1'b0, quo_nxt};
        if (zero_r) begin
          q_nxt = '0;
        end else if (!sq[NW] && (sq[NW-1:beg_pkg::LevelW-1] != '0)) begin
          q_nxt = beg_pkg::SatMax;
        end else if (sq[NW] && (sq[NW-1:beg_pkg::LevelW-1] != '1)) begin
          q_nxt = beg_pkg::SatMin;
        end else begin
          q_nxt = sq[beg_pkg::LevelW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    q_r    <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

### design/brightness_envelope_generator_top.sv
// Top level of the brightness envelope generator: command sequencer and state.
//
//  channel | signals                        | direction
//  in      | in_valid in_ready in_data      | item in
//  out     | out_valid out_ready out_data   | item out
//  cfg     | cfg_we cfg_index cfg_wdata     | register write
//
// An item with division waits in ST_DIV for the 34-step shared divider;
// one without goes straight to ST_OUT. Ready is low from accept until the
// result is loaded into the output register; a held result stalls the next
// item only at load time. Reset is synchronous, active low.
module brightness_envelope_generator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  beg_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output beg_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_OUT} state_t;
  typedef enum logic [2:0] {
    DK_GLIDE, DK_LOOP, DK_BEAT, DK_LOOP_DN, DK_LOOP_UP, DK_FALL, DK_RISE
  } dkind_t;

  state_t state_r, state_nxt;
  dkind_t dk_r, dk_nxt;

  logic signed [31:0] top_r, bot_r;
  logic signed [31:0] lvl_r, lvl_nxt, spd_r, spd_nxt, chg_r, chg_nxt;
  logic signed [31:0] goal_r, goal_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] half_r, half_nxt, stopc_r, stopc_nxt, per_r, per_nxt;
  logic [15:0] rise_r, rise_nxt, pause_r, pause_nxt;
  logic [31:0] bstart_r, bstart_nxt, fc_r, fc_nxt;
  logic        ov_r, ov_nxt;
  beg_pkg::out_item_t od_r, od_nxt;

  beg_pkg::div_req_t dreq;
  beg_pkg::div_rsp_t drsp;
  logic signed [32:0] span;
  logic signed [31:0] sum;
  logic [15:0] halfi;
  logic        half_stop;

  beg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r; dk_nxt = dk_r;
    lvl_nxt = lvl_r; spd_nxt = spd_r; chg_nxt = chg_r; goal_nxt = goal_r;
    mode_nxt = mode_r; half_nxt = half_r; stopc_nxt = stopc_r; per_nxt = per_r;
    rise_nxt = rise_r; pause_nxt = pause_r; bstart_nxt = bstart_r; fc_nxt = fc_r;
    ov_nxt = ov_r && !out_ready;
    od_nxt = od_r;
    dreq = '0;
    span = {top_r[31], top_r} - {bot_r[31], bot_r};
    sum = beg_pkg::sat_add(lvl_r, spd_r);
    halfi = half_r + 16'd1;
    half_stop = (stopc_r != '0) && (halfi == stopc_r);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_OUT;
          case (in_data.func)
            beg_pkg::FuncTick: begin
              if (mode_r != beg_pkg::ModeIdle) begin
                fc_nxt = fc_r + 32'd1;
                if (mode_r == beg_pkg::ModeLin || mode_r == beg_pkg::ModeAcc) begin
                  lvl_nxt = sum;
                  if ((spd_r > 0 && goal_r <= sum) || (spd_r < 0 && goal_r >= sum)) begin
                    lvl_nxt = goal_r;
                    mode_nxt = beg_pkg::ModeIdle;
                  end
                  if (mode_r == beg_pkg::ModeAcc) begin
                    spd_nxt = beg_pkg::sat_add(spd_r, chg_r);
                  end
                end else if (mode_r == beg_pkg::ModeLoop) begin
                  lvl_nxt = sum;
                  if (top_r <= sum) begin
                    lvl_nxt = top_r; half_nxt = halfi;
                    if (half_stop) mode_nxt = beg_pkg::ModeIdle;
                    dreq.start = 1'b1; dreq.num = -(34'(span) <<< 1);
                    dreq.den = 18'({2'b0, per_r}); dk_nxt = DK_LOOP_DN;
                    state_nxt = ST_DIV;
                  end else if (bot_r >= sum) begin
                    lvl_nxt = bot_r; half_nxt = halfi;
                    if (half_stop) mode_nxt = beg_pkg::ModeIdle;
                    dreq.start = 1'b1; dreq.num = 34'(span) <<< 1;
                    dreq.den = 18'({2'b0, per_r}); dk_nxt = DK_LOOP_UP;
                    state_nxt = ST_DIV;
                  end
                end else if (mode_r == beg_pkg::ModeBeat) begin
                  lvl_nxt = sum;
                  if (bstart_r + 32'(rise_r) == fc_r) begin
                    lvl_nxt = top_r; half_nxt = halfi;
                    if (half_stop) mode_nxt = beg_pkg::ModeIdle;
                    dreq.start = 1'b1; dreq.num = -34'(span);
                    dreq.den = 18'(per_r) - 18'(rise_r) - 18'(pause_r);
                    dk_nxt = DK_FALL; state_nxt = ST_DIV;
                  end else if (bot_r > sum) begin
                    lvl_nxt = bot_r; spd_nxt = '0;
                  end else if (bstart_r + 32'(per_r) == fc_r) begin
                    bstart_nxt = fc_r; half_nxt = halfi;
                    if (half_stop) mode_nxt = beg_pkg::ModeIdle;
                    dreq.start = 1'b1; dreq.num = 34'(span);
                    dreq.den = 18'(rise_r); dk_nxt = DK_RISE; state_nxt = ST_DIV;
                  end
                end
              end
            end
            beg_pkg::FuncGlide: begin
              goal_nxt = in_data.target;
              dreq.start = 1'b1;
              dreq.num = 34'(in_data.target) - 34'(lvl_r);
              dreq.den = 18'(in_data.spend_frames);
              dk_nxt = DK_GLIDE; state_nxt = ST_DIV;
            end
            beg_pkg::FuncStep: begin
              mode_nxt = beg_pkg::ModeLin; goal_nxt = in_data.target;
              if (in_data.target > lvl_r) spd_nxt = in_data.velocity;
              else if (in_data.target < lvl_r)
                spd_nxt = (in_data.velocity == beg_pkg::SatMin) ? beg_pkg::SatMax
                          : -in_data.velocity;
              else spd_nxt = '0;
            end
            beg_pkg::FuncAccel: begin
              mode_nxt = beg_pkg::ModeAcc; goal_nxt = in_data.target;
              spd_nxt = in_data.velocity; chg_nxt = in_data.accel;
            end
            beg_pkg::FuncLoop: begin
              mode_nxt = beg_pkg::ModeLoop; half_nxt = '0;
              stopc_nxt = in_data.half_beats; per_nxt = in_data.spend_frames;
              dreq.start = 1'b1;
              dreq.num = 34'(top_r) - 34'(lvl_r);
              dreq.den = 18'(in_data.spend_frames >> 1);
              dk_nxt = DK_LOOP; state_nxt = ST_DIV;
            end
            beg_pkg::FuncBeat: begin
              mode_nxt = beg_pkg::ModeBeat; half_nxt = '0;
              stopc_nxt = in_data.half_beats; rise_nxt = in_data.attack_frames;
              pause_nxt = in_data.rest_frames; bstart_nxt = fc_r;
              per_nxt = in_data.spend_frames;
              dreq.start = 1'b1;
              dreq.num = 34'(top_r) - 34'(lvl_r);
              dreq.den = 18'(in_data.attack_frames);
              dk_nxt = DK_BEAT; state_nxt = ST_DIV;
            end
            beg_pkg::FuncStop: mode_nxt = beg_pkg::ModeIdle;
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          spd_nxt = drsp.quot;
          state_nxt = ST_OUT;
          case (dk_r)
            DK_GLIDE: mode_nxt = (drsp.quot == '0) ? beg_pkg::ModeIdle : beg_pkg::ModeLin;
            DK_LOOP: if (drsp.quot == '0) spd_nxt = beg_pkg::LevelTenth;
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt.level = lvl_r;
          od_nxt.mode = mode_r;
          od_nxt.frame_number = fc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; dk_r <= DK_GLIDE;
      top_r <= beg_pkg::TopReset; bot_r <= beg_pkg::BotReset;
      lvl_r <= beg_pkg::LevelOne; spd_r <= '0; chg_r <= '0;
      goal_r <= beg_pkg::LevelOne; mode_r <= beg_pkg::ModeIdle;
      half_r <= '0; stopc_r <= '0; per_r <= '0; rise_r <= '0; pause_r <= '0;
      bstart_r <= '0; fc_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; dk_r <= dk_nxt;
      if (cfg_we && cfg_index == beg_pkg::CfgTop) top_r <= cfg_wdata;
      if (cfg_we && cfg_index == beg_pkg::CfgBot) bot_r <= cfg_wdata;
      lvl_r <= lvl_nxt; spd_r <= spd_nxt; chg_r <= chg_nxt;
      goal_r <= goal_nxt; mode_r <= mode_nxt;
      half_r <= half_nxt; stopc_r <= stopc_nxt; per_r <= per_nxt;
      rise_r <= rise_nxt; pause_r <= pause_nxt;
      bstart_r <= bstart_nxt; fc_r <= fc_nxt; ov_r <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == ST_DIV) else $error("divider result outside wait");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !in_ready) else $error("ready while dividing");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && (!ov_r || out_ready)) |=> out_valid && state_r == ST_IDLE)
    else $error("result not loaded");

endmodule
